>>> hdl/aldc_pkg.sv
// Shared constants and types for the adjacent line dedup counter.
`timescale 1ns / 1ps

package aldc_pkg;

    localparam int ALDC_LINE_BYTES = 31;

    localparam logic [7:0]  NEWLINE   = 8'd10;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SHOW_COUNTS,
        CFG_DUPS_ONLY
    } cfg_index_t;

endpackage

>>> hdl/aldc_if.sv
// Stream interfaces for text bytes in and emitted result items out.
`timescale 1ns / 1ps

interface aldc_in_if;
    logic                        valid;
    logic                        ready;
    logic [aldc_pkg::BYTE_W-1:0] in_byte;
    logic                        flush;

    modport source (output valid, output in_byte, output flush, input ready);
    modport sink   (input valid, input in_byte, input flush, output ready);
endinterface

interface aldc_out_if;
    logic                         valid;
    logic                         ready;
    logic [aldc_pkg::BYTE_W-1:0]  out_byte;
    logic [aldc_pkg::COUNT_W-1:0] dup_count;
    logic                         count_shown;
    logic                         line_end;
    logic                         last_result;

    modport source (output valid, output out_byte, output dup_count, output count_shown,
                    output line_end, output last_result, input ready);
    modport sink   (input valid, input out_byte, input dup_count, input count_shown,
                    input line_end, input last_result, output ready);
endinterface

>>> hdl/adjacent_line_dedup_counter.sv
// A text byte goes through S_IDLE (RAM read of the previous line), then S_CMP (compare).
// A newline with nothing to emit closes in S_IDLE, a flush ends in S_FINAL; input is
// held off while a run is emitted, each stored byte via S_ERD then S_EOUT and the
// closing newline via S_ENL, set by the single read port of the line RAM. No new byte
// is taken until the last is compared. Reset clears all control state and registers;
// the line RAM is not cleared and holds nothing meaningful until written.
`timescale 1ns / 1ps

module adjacent_line_dedup_counter #(
    parameter int LINE_BYTES = aldc_pkg::ALDC_LINE_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    aldc_in_if.sink                             text,
    aldc_out_if.source                          result,
    input  logic                                cfg_we,
    input  logic [aldc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [aldc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import aldc_pkg::*;

    localparam int LW    = $clog2(LINE_BYTES + 1);
    localparam int AW    = LW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam logic [LW-1:0] LEN_FULL = LW'(LINE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FINAL,
        S_ERD,
        S_EOUT,
        S_ENL
    } state_t;

    state_t              state_reg, state_next;
    logic                sel_reg, sel_next;
    logic [LW-1:0]       cur_len_reg, cur_len_next;
    logic [LW-1:0]       prev_len_reg, prev_len_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                has_prev_reg, has_prev_next;
    logic                match_reg, match_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                esel_reg, esel_next;
    logic [LW-1:0]       eidx_reg, eidx_next;
    logic [LW-1:0]       elen_reg, elen_next;
    logic [COUNT_W-1:0]  ecnt_reg, ecnt_next;
    logic                flush_pend_reg, flush_pend_next;
    logic                fin_reg, fin_next;
    logic                show_reg, show_next;
    logic                dups_reg, dups_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [COUNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                out_shown_reg, out_shown_next;
    logic                out_end_reg, out_end_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [BYTE_W-1:0]   ram_rdata;

    logic                slot_free;
    logic                match_cmp;
    logic [LW-1:0]       len_inc;
    logic [LW-1:0]       el_len;
    logic                el_match;
    logic                el_same;
    logic                el_emit;
    logic                run_emit;
    logic [COUNT_W-1:0]  cnt_inc;
    state_t              emit_state;

    aldc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_next),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign text.ready         = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.dup_count   = out_cnt_reg;
    assign result.count_shown = out_shown_reg;
    assign result.line_end    = out_end_reg;
    assign result.last_result = out_last_reg;

    assign slot_free = !out_valid_reg || result.ready;
    assign len_inc   = cur_len_reg + LW'(1);
    assign match_cmp = match_reg && (cur_len_reg < prev_len_reg) && (ram_rdata == byte_reg);
    assign el_len    = (state_reg == S_CMP) ? len_inc : cur_len_reg;
    assign el_match  = (state_reg == S_CMP) ? match_cmp : match_reg;
    assign el_same   = has_prev_reg && el_match && (el_len == prev_len_reg);
    assign run_emit  = has_prev_reg && !(dups_reg && (cnt_reg <= COUNT_W'(1)));
    assign el_emit   = !el_same && run_emit;
    assign cnt_inc   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + COUNT_W'(1);
    assign emit_state = (prev_len_reg == '0) ? S_ENL : S_ERD;

    assign ram_waddr = {sel_reg, cur_len_reg};
    assign ram_raddr = (state_reg == S_IDLE) ? {~sel_reg, cur_len_reg} : {esel_reg, eidx_reg};

    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        cur_len_next    = cur_len_reg;
        prev_len_next   = prev_len_reg;
        cnt_next        = cnt_reg;
        has_prev_next   = has_prev_reg;
        match_next      = match_reg;
        byte_next       = text.in_byte;
        esel_next       = esel_reg;
        eidx_next       = eidx_reg;
        elen_next       = elen_reg;
        ecnt_next       = ecnt_reg;
        flush_pend_next = flush_pend_reg;
        fin_next        = fin_reg;
        show_next       = show_reg;
        dups_next       = dups_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_byte_next   = out_byte_reg;
        out_cnt_next    = out_cnt_reg;
        out_shown_next  = out_shown_reg;
        out_end_next    = out_end_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SHOW_COUNTS: show_next = cfg_data[0];
                CFG_DUPS_ONLY:   dups_next = cfg_data[0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (text.valid)
                begin
                    if (text.flush || text.in_byte == NEWLINE)
                    begin
                        if (!text.flush || cur_len_reg != '0)
                        begin
                            // close the current line against the stored run
                            if (el_same)
                            begin
                                cnt_next = cnt_inc;
                            end
                            else
                            begin
                                sel_next      = ~sel_reg;
                                prev_len_next = el_len;
                                cnt_next      = COUNT_W'(1);
                                has_prev_next = 1'b1;
                            end
                            cur_len_next = '0;
                            match_next   = 1'b1;
                        end
                        if ((!text.flush || cur_len_reg != '0) && el_emit)
                        begin
                            esel_next       = ~sel_reg;
                            eidx_next       = '0;
                            elen_next       = prev_len_reg;
                            ecnt_next       = cnt_reg;
                            flush_pend_next = text.flush;
                            state_next      = emit_state;
                        end
                        else if (text.flush)
                        begin
                            state_next = S_FINAL;
                        end
                    end
                    else if (cur_len_reg < LEN_FULL)
                    begin
                        ram_we     = 1'b1;
                        state_next = S_CMP;
                    end
                end
            end

            S_CMP:
            begin
                cur_len_next = len_inc;
                match_next   = match_cmp;
                state_next   = S_IDLE;
                if (len_inc == LEN_FULL)
                begin
                    // a full store ends the line as a chunk
                    if (el_same)
                    begin
                        cnt_next = cnt_inc;
                    end
                    else
                    begin
                        sel_next      = ~sel_reg;
                        prev_len_next = el_len;
                        cnt_next      = COUNT_W'(1);
                        has_prev_next = 1'b1;
                    end
                    cur_len_next = '0;
                    match_next   = 1'b1;
                    if (el_emit)
                    begin
                        esel_next       = ~sel_reg;
                        eidx_next       = '0;
                        elen_next       = prev_len_reg;
                        ecnt_next       = cnt_reg;
                        flush_pend_next = 1'b0;
                        state_next      = emit_state;
                    end
                end
            end

            S_FINAL:
            begin
                if (run_emit)
                begin
                    esel_next  = ~sel_reg;
                    eidx_next  = '0;
                    elen_next  = prev_len_reg;
                    ecnt_next  = cnt_reg;
                    fin_next   = 1'b1;
                    state_next = emit_state;
                end
                else
                begin
                    has_prev_next = 1'b0;
                    prev_len_next = '0;
                    cnt_next      = '0;
                    cur_len_next  = '0;
                    match_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_ERD:
            begin
                state_next = S_EOUT;
            end

            S_EOUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_cnt_next   = ecnt_reg;
                    out_shown_next = show_reg;
                    out_end_next   = 1'b0;
                    out_last_next  = 1'b0;
                    eidx_next      = eidx_reg + LW'(1);
                    state_next     = (eidx_reg + LW'(1) == elen_reg) ? S_ENL : S_ERD;
                end
            end

            S_ENL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = NEWLINE;
                    out_cnt_next   = ecnt_reg;
                    out_shown_next = show_reg;
                    out_end_next   = 1'b1;
                    out_last_next  = !(flush_pend_reg && run_emit);
                    if (flush_pend_reg)
                    begin
                        flush_pend_next = 1'b0;
                        state_next      = S_FINAL;
                    end
                    else if (fin_reg)
                    begin
                        fin_next      = 1'b0;
                        has_prev_next = 1'b0;
                        prev_len_next = '0;
                        cnt_next      = '0;
                        cur_len_next  = '0;
                        match_next    = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sel_reg        <= 1'b0;
            cur_len_reg    <= '0;
            prev_len_reg   <= '0;
            cnt_reg        <= '0;
            has_prev_reg   <= 1'b0;
            match_reg      <= 1'b1;
            byte_reg       <= '0;
            esel_reg       <= 1'b0;
            eidx_reg       <= '0;
            elen_reg       <= '0;
            ecnt_reg       <= '0;
            flush_pend_reg <= 1'b0;
            fin_reg        <= 1'b0;
            show_reg       <= 1'b0;
            dups_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_cnt_reg    <= '0;
            out_shown_reg  <= 1'b0;
            out_end_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_reg        <= sel_next;
            cur_len_reg    <= cur_len_next;
            prev_len_reg   <= prev_len_next;
            cnt_reg        <= cnt_next;
            has_prev_reg   <= has_prev_next;
            match_reg      <= match_next;
            byte_reg       <= byte_next;
            esel_reg       <= esel_next;
            eidx_reg       <= eidx_next;
            elen_reg       <= elen_next;
            ecnt_reg       <= ecnt_next;
            flush_pend_reg <= flush_pend_next;
            fin_reg        <= fin_next;
            show_reg       <= show_next;
            dups_reg       <= dups_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_cnt_reg    <= out_cnt_next;
            out_shown_reg  <= out_shown_next;
            out_end_reg    <= out_end_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule

>>> hdl/aldc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module aldc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> verif/adjacent_line_dedup_counter_test.sv
// Self-checking testbench for the adjacent line dedup counter: text stimulus, result checks.
`timescale 1ns / 1ps

module adjacent_line_dedup_counter_test;
    import aldc_pkg::*;

    localparam int LINE_LIMIT    = ALDC_LINE_BYTES;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [BYTE_W-1:0] text_byte;
        logic              flush;
        bit                after_drain;
    } text_item_t;

    typedef struct {
        logic [BYTE_W-1:0]  out_byte;
        logic [COUNT_W-1:0] dup_count;
        logic               count_shown;
        logic               line_end;
        logic               last_result;
    } emitted_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    aldc_in_if  text ();
    aldc_out_if result ();

    adjacent_line_dedup_counter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // line filter state mirrored here
    logic [BYTE_W-1:0]  line_store [2][LINE_LIMIT];
    bit                 gather_sel = 1'b0;
    int                 gather_len = 0;
    int                 held_len = 0;
    logic [COUNT_W-1:0] run_len = '0;
    bit                 held_valid = 1'b0;
    bit                 still_equal = 1'b1;
    bit                 show_cfg = 1'b0;
    bit                 dups_cfg = 1'b0;

    emitted_t   pending_emits[$];
    emitted_t   step_emits[$];
    text_item_t text_backlog[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;
    bit          hold_for_drain = 1'b0;
    int          queued_total = 0;
    int          failures = 0;
    int          quiet_cycles = 0;

    logic [BYTE_W-1:0] pool_bytes [4][LINE_LIMIT];
    int                pool_len [4];

    task automatic push_emit(input logic [BYTE_W-1:0] b, input logic closing);
        emitted_t r;
        r.out_byte    = b;
        r.dup_count   = run_len;
        r.count_shown = show_cfg;
        r.line_end    = closing;
        r.last_result = 1'b0;
        step_emits.push_back(r);
    endtask

    task automatic emit_held_run();
        if (!held_valid || (dups_cfg && run_len <= 1))
            return;
        for (int i = 0; i < held_len; i++)
            push_emit(line_store[!gather_sel][i], 1'b0);
        push_emit(NEWLINE, 1'b1);
    endtask

    task automatic close_line();
        if (held_valid && still_equal && gather_len == held_len)
        begin
            if (run_len != COUNT_MAX)
                run_len++;
        end
        else
        begin
            emit_held_run();
            gather_sel = !gather_sel;
            held_len   = gather_len;
            run_len    = COUNT_W'(1);
            held_valid = 1'b1;
        end
        gather_len  = 0;
        still_equal = 1'b1;
    endtask

    task automatic uniq_step(input text_item_t it);
        step_emits.delete();
        if (it.flush)
        begin
            if (gather_len > 0)
                close_line();
            emit_held_run();
            held_valid  = 1'b0;
            held_len    = 0;
            run_len     = '0;
            gather_len  = 0;
            still_equal = 1'b1;
        end
        else if (it.text_byte == NEWLINE)
            close_line();
        else if (gather_len < LINE_LIMIT)
        begin
            if (gather_len >= held_len || line_store[!gather_sel][gather_len] != it.text_byte)
                still_equal = 1'b0;
            line_store[gather_sel][gather_len] = it.text_byte;
            gather_len++;
            if (gather_len >= LINE_LIMIT)
                close_line();
        end
        if (step_emits.size() > 0)
            step_emits[step_emits.size() - 1].last_result = 1'b1;
        foreach (step_emits[i])
            pending_emits.push_back(step_emits[i]);
    endtask

    always @(posedge clk)
    begin : text_driver
        bit offer;
        offer = text.valid;
        if (rst_n)
        begin
            if (text.valid && text.ready)
            begin
                uniq_step(text_backlog.pop_front());
                offer = 1'b0;
            end
            if (!offer && text_backlog.size() > 0)
                offer = !(text_backlog[0].after_drain && pending_emits.size() > 0)
                        && $urandom_range(99) >= send_idle_pct;
            if (offer)
            begin
                text.in_byte <= text_backlog[0].text_byte;
                text.flush   <= text_backlog[0].flush;
            end
            text.valid <= offer;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        emitted_t want;
        emitted_t got;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                got.out_byte    = result.out_byte;
                got.dup_count   = result.dup_count;
                got.count_shown = result.count_shown;
                got.line_end    = result.line_end;
                got.last_result = result.last_result;
                if (pending_emits.size() == 0)
                begin
                    $display("%0t: unexpected item: byte %0d count %0d shown %0b end %0b last %0b",
                             $time, got.out_byte, got.dup_count, got.count_shown,
                             got.line_end, got.last_result);
                    failures++;
                end
                else
                begin
                    want = pending_emits.pop_front();
                    if (got.out_byte !== want.out_byte || got.dup_count !== want.dup_count
                        || got.count_shown !== want.count_shown
                        || got.line_end !== want.line_end
                        || got.last_result !== want.last_result)
                    begin
                        $display("%0t: mismatch: expected byte %0d count %0d shown %0b end %0b last %0b",
                                 $time, want.out_byte, want.dup_count, want.count_shown,
                                 want.line_end, want.last_result);
                        $display("%0t:           actual byte %0d count %0d shown %0b end %0b last %0b",
                                 $time, got.out_byte, got.dup_count, got.count_shown,
                                 got.line_end, got.last_result);
                        failures++;
                    end
                end
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((text.valid && text.ready) || (result.valid && result.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("adjacent_line_dedup_counter test failed");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == NEWLINE);
        return b;
    endfunction

    task automatic queue_item(input logic [BYTE_W-1:0] b, input logic f);
        text_item_t it;
        it.text_byte   = b;
        it.flush       = f;
        it.after_drain = hold_for_drain;
        hold_for_drain = 1'b0;
        text_backlog.push_back(it);
        queued_total++;
    endtask

    task automatic refresh_slot(input int slot, input int len);
        pool_len[slot] = len;
        for (int i = 0; i < len; i++)
            pool_bytes[slot][i] = plain_byte();
    endtask

    task automatic refresh_slot_random(input int slot);
        if ($urandom_range(9) < 7)
            refresh_slot(slot, $urandom_range(5));
        else
            refresh_slot(slot, $urandom_range(6, LINE_LIMIT));
    endtask

    task automatic queue_line(input int slot);
        for (int i = 0; i < pool_len[slot]; i++)
            queue_item(pool_bytes[slot][i], 1'b0);
        if (pool_len[slot] < LINE_LIMIT || $urandom_range(1))
            queue_item(NEWLINE, 1'b0);
    endtask

    task automatic queue_random_text(input int amount);
        int start;
        int kind;
        int slot;
        int cut;
        start = queued_total;
        while (queued_total - start < amount)
        begin
            kind = $urandom_range(99);
            slot = $urandom_range(3);
            hold_for_drain = ($urandom_range(99) < 4);
            if (kind < 66)
                repeat ($urandom_range(1, 4)) queue_line(slot);
            else if (kind < 78)
            begin
                // near duplicate: same prefix, then a changed byte or an early end
                queue_line(slot);
                cut = $urandom_range(pool_len[slot]);
                for (int i = 0; i < cut; i++)
                    queue_item(pool_bytes[slot][i], 1'b0);
                if ($urandom_range(1))
                begin
                    queue_item(plain_byte(), 1'b0);
                    for (int i = cut + 1; i < pool_len[slot]; i++)
                        queue_item(pool_bytes[slot][i], 1'b0);
                end
                queue_item(NEWLINE, 1'b0);
            end
            else if (kind < 86)
                repeat ($urandom_range(1, 5)) queue_item(BYTE_W'($urandom_range(255)), 1'b0);
            else if (kind < 92)
            begin
                refresh_slot(slot, LINE_LIMIT);
                repeat ($urandom_range(1, 3)) queue_line(slot);
            end
            else if (kind < 96)
                refresh_slot_random(slot);
            else
                queue_item(BYTE_W'($urandom_range(255)), 1'b1);
        end
        hold_for_drain = 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (text_backlog.size() > 0 || text.valid || pending_emits.size() > 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input cfg_index_t idx, input bit value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SHOW_COUNTS)
            show_cfg = value;
        else
            dups_cfg = value;
    endtask

    task automatic start_phase(input bit show, input bit dups, input int unsigned send_pct,
                               input int unsigned recv_pct);
        wait_idle();
        write_config(CFG_SHOW_COUNTS, show);
        write_config(CFG_DUPS_ONLY, dups);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(negedge clk);
    endtask

    task automatic start_random_phase(input bit show, input bit dups, input int unsigned send_pct,
                                      input int unsigned recv_pct);
        start_phase(show, dups, send_pct, recv_pct);
        for (int s = 0; s < 4; s++)
            refresh_slot_random(s);
    endtask

    initial
    begin : stimulus
        text.valid   = 1'b0;
        text.in_byte = '0;
        text.flush   = 1'b0;
        result.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        start_phase(1'b0, 1'b0, 0, 0);
        queue_item(8'd0, 1'b1);
        queue_item(NEWLINE, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd0, 1'b0);
        queue_item(8'd255, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd0, 1'b0);
        queue_item(8'd255, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd0, 1'b0);
        queue_item(8'd254, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd0, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd255, 1'b1);
        queue_item(8'd97, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd98, 1'b0);
        queue_item(8'd0, 1'b1);

        start_phase(1'b1, 1'b1, 0, 0);
        queue_item(8'd120, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd121, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd121, 1'b0);
        queue_item(NEWLINE, 1'b0);
        queue_item(8'd0, 1'b1);

        start_random_phase(1'b0, 1'b0, 0, 0);
        queue_random_text(30);
        start_random_phase(1'b1, 1'b0, 70, 0);
        queue_random_text(30);
        start_random_phase(1'b0, 1'b1, 0, 70);
        queue_random_text(30);
        start_random_phase(1'b1, 1'b1, 18, 18);
        queue_random_text(30);

        // hold the receiver off while text keeps coming, then pause until drained
        start_random_phase(1'b1, 1'b0, 0, 0);
        hold_request = 400;
        refresh_slot(0, LINE_LIMIT);
        queue_line(0);
        queue_line(0);
        queue_random_text(15);
        hold_for_drain = 1'b1;
        queue_line(0);
        queue_random_text(10);

        wait_idle();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("adjacent_line_dedup_counter test passed");
        else
            $display("adjacent_line_dedup_counter test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/aldc_pkg.sv
hdl/aldc_if.sv
hdl/aldc_ram.sv
hdl/adjacent_line_dedup_counter.sv
verif/adjacent_line_dedup_counter_test.sv
